// ===== hdl/bmsc_pkg.sv =====
// shared types and constants for the button mode session controller
// no dependencies
package bmsc_pkg;

  localparam int unsigned DebounceW = 8;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned SessionW  = 24;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [DebounceW-1:0] DebounceReset = 8'd50;
  localparam logic [HoldW-1:0]     LongPressReset = 16'd3000;
  localparam logic [SessionW-1:0]  SessionReset = 24'd900000;

  localparam logic [DebounceW-1:0] StableMax  = '1;
  localparam logic [HoldW-1:0]     HoldMax    = '1;
  localparam logic [SessionW-1:0]  SessionMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_SESSION    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic held;
    logic press;
  } key_evt_t;

  typedef struct packed {
    logic [HoldW-1:0]    long_press_ticks;
    logic [SessionW-1:0] session_ticks;
  } limits_t;

  typedef struct packed {
    logic             asleep;
    logic [ModeW-1:0] mode;
  } ctl_state_t;

endpackage

// ===== hdl/button_mode_session_controller.sv =====
// top level: config registers, debouncer, session control and result register
// depends on bmsc_pkg, bmsc_debounce, bmsc_session
// a result beat appears in the cycle after its sample beat is accepted
// throughput: one sample beat per cycle, held off only while a result is stalled
// state is updated in the accepting cycle by the debouncer and session control
// reset (synchronous, rst_n low) restores default limits, mode 0 and asleep
module button_mode_session_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bmsc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [bmsc_pkg::CfgDataW-1:0]    cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_button_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_heater_on,
  output logic                             out_drive_left,
  output logic                             out_drive_right,
  output logic                             out_sleeping,
  output logic [bmsc_pkg::ModeW-1:0]       out_current_mode
);

  logic [bmsc_pkg::DebounceW-1:0] debounce_r;
  logic [bmsc_pkg::HoldW-1:0]     long_press_r;
  logic [bmsc_pkg::SessionW-1:0]  session_lim_r;
  bmsc_pkg::limits_t              limits;
  bmsc_pkg::key_evt_t             evt;
  bmsc_pkg::ctl_state_t           state_nxt;
  logic                           accept;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  bmsc_pkg::ctl_state_t           res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= bmsc_pkg::DebounceReset;
      long_press_r  <= bmsc_pkg::LongPressReset;
      session_lim_r <= bmsc_pkg::SessionReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmsc_pkg::CFG_DEBOUNCE:   debounce_r    <= cfg_data[bmsc_pkg::DebounceW-1:0];
        bmsc_pkg::CFG_LONG_PRESS: long_press_r  <= cfg_data[bmsc_pkg::HoldW-1:0];
        bmsc_pkg::CFG_SESSION:    session_lim_r <= cfg_data[bmsc_pkg::SessionW-1:0];
        default: ;
      endcase
    end
  end

  assign limits.long_press_ticks = long_press_r;
  assign limits.session_ticks    = session_lim_r;

  assign in_stall      = out_valid_r & out_stall;
  assign accept        = in_valid & ~in_stall;
  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  bmsc_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (accept),
    .sample         (in_button_level),
    .debounce_ticks (debounce_r),
    .evt            (evt)
  );

  bmsc_session u_session (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (accept),
    .evt       (evt),
    .limits    (limits),
    .state_nxt (state_nxt)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= state_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sleeping     = res_r.asleep;
  assign out_current_mode = res_r.mode;
  assign out_heater_on    = ~res_r.asleep & res_r.mode[1];
  assign out_drive_left   = ~res_r.asleep & ~res_r.mode[0];
  assign out_drive_right  = ~res_r.asleep & res_r.mode[0];

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted sample produced no result beat");

  a_sleep_drives_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sleeping |-> !out_heater_on && !out_drive_left && !out_drive_right)
    else $error("drive active while sleeping");

  a_awake_one_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sleeping |-> out_drive_left != out_drive_right)
    else $error("motor drives not exclusive while awake");

  a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !accept)
    else $error("sample accepted over a stalled result");

endmodule

// ===== hdl/bmsc_debounce.sv =====
// sample debouncer and press edge detector
// depends on bmsc_pkg
module bmsc_debounce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          sample,
  input  logic [bmsc_pkg::DebounceW-1:0] debounce_ticks,
  output bmsc_pkg::key_evt_t            evt
);

  logic                           last_sample_r;
  logic                           last_sample_nxt;
  logic [bmsc_pkg::DebounceW-1:0] stable_count_r;
  logic [bmsc_pkg::DebounceW-1:0] stable_count_nxt;
  logic                           key_down_r;
  logic                           key_down_nxt;
  logic                           prev_key_down_r;

  always_comb begin
    last_sample_nxt = sample;
    if (sample != last_sample_r) begin
      stable_count_nxt = '0;
    end else if (stable_count_r != bmsc_pkg::StableMax) begin
      stable_count_nxt = stable_count_r + 1'b1;
    end else begin
      stable_count_nxt = stable_count_r;
    end
    if (stable_count_nxt >= debounce_ticks) begin
      key_down_nxt = ~sample;
    end else begin
      key_down_nxt = key_down_r;
    end
    evt.held  = key_down_nxt;
    evt.press = key_down_nxt & ~prev_key_down_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r   <= 1'b1;
      stable_count_r  <= '0;
      key_down_r      <= 1'b0;
      prev_key_down_r <= 1'b0;
    end else if (en) begin
      last_sample_r   <= last_sample_nxt;
      stable_count_r  <= stable_count_nxt;
      key_down_r      <= key_down_nxt;
      prev_key_down_r <= key_down_nxt;
    end
  end

endmodule

// ===== hdl/bmsc_session.sv =====
// mode, hold and session timers with sleep and wake control
// depends on bmsc_pkg
module bmsc_session (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  bmsc_pkg::key_evt_t    evt,
  input  bmsc_pkg::limits_t     limits,
  output bmsc_pkg::ctl_state_t  state_nxt
);

  logic                          asleep_r;
  logic                          asleep_nxt;
  logic [bmsc_pkg::ModeW-1:0]    mode_r;
  logic [bmsc_pkg::ModeW-1:0]    mode_nxt;
  logic                          pending_r;
  logic                          pending_nxt;
  logic [bmsc_pkg::HoldW-1:0]    hold_r;
  logic [bmsc_pkg::HoldW-1:0]    hold_nxt;
  logic [bmsc_pkg::SessionW-1:0] session_r;
  logic [bmsc_pkg::SessionW-1:0] session_nxt;
  logic                          pend1;
  logic [bmsc_pkg::HoldW-1:0]    hold1;
  logic [bmsc_pkg::SessionW-1:0] session1;
  logic                          short_press;
  logic                          long_press;
  logic                          timeout;

  always_comb begin
    pend1    = pending_r | evt.press;
    session1 = (session_r != bmsc_pkg::SessionMax) ? session_r + 1'b1 : session_r;
    if (evt.press) begin
      hold1 = '0;
    end else if (pending_r && evt.held && hold_r != bmsc_pkg::HoldMax) begin
      hold1 = hold_r + 1'b1;
    end else begin
      hold1 = hold_r;
    end
    short_press = pend1 & ~evt.held;
    long_press  = pend1 & evt.held & (hold1 >= limits.long_press_ticks);
    timeout     = session1 >= limits.session_ticks;

    asleep_nxt  = asleep_r;
    mode_nxt    = mode_r;
    pending_nxt = pending_r;
    hold_nxt    = hold_r;
    session_nxt = session_r;
    if (asleep_r) begin
      if (evt.press) begin
        asleep_nxt  = 1'b0;
        session_nxt = '0;
      end
    end else begin
      pending_nxt = pend1;
      hold_nxt    = hold1;
      session_nxt = session1;
      if (long_press || timeout) begin
        asleep_nxt  = 1'b1;
        pending_nxt = 1'b0;
        hold_nxt    = '0;
        session_nxt = '0;
      end else if (short_press) begin
        pending_nxt = 1'b0;
        mode_nxt    = mode_r + 1'b1;
        session_nxt = '0;
      end
    end
    state_nxt.asleep = asleep_nxt;
    state_nxt.mode   = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asleep_r  <= 1'b1;
      mode_r    <= '0;
      pending_r <= 1'b0;
      hold_r    <= '0;
      session_r <= '0;
    end else if (en) begin
      asleep_r  <= asleep_nxt;
      mode_r    <= mode_nxt;
      pending_r <= pending_nxt;
      hold_r    <= hold_nxt;
      session_r <= session_nxt;
    end
  end

endmodule

// ===== bench/tb_button_mode_session_controller.sv =====
// self-checking bench for button_mode_session_controller: debounce, short and long press,
// wake and session timeout, checked beat by beat against a predictor of the control state
// depends on bmsc_pkg and the button_mode_session_controller rtl
`timescale 1ns / 100ps

module tb_button_mode_session_controller;

  localparam logic [bmsc_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct packed {
    logic                       heater;
    logic                       left;
    logic                       right;
    logic                       sleeping;
    logic [bmsc_pkg::ModeW-1:0] mode;
  } drive_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [bmsc_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [bmsc_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_button_level = 1'b1;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_heater_on;
  logic                          out_drive_left;
  logic                          out_drive_right;
  logic                          out_sleeping;
  logic [bmsc_pkg::ModeW-1:0]    out_current_mode;

  button_mode_session_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_button_level  (in_button_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_heater_on    (out_heater_on),
    .out_drive_left   (out_drive_left),
    .out_drive_right  (out_drive_right),
    .out_sleeping     (out_sleeping),
    .out_current_mode (out_current_mode)
  );

  always #2 clk = ~clk;

  // predicted limits and control state
  logic [bmsc_pkg::DebounceW-1:0] lim_debounce;
  logic [bmsc_pkg::HoldW-1:0]     lim_long;
  logic [bmsc_pkg::SessionW-1:0]  lim_session;
  logic [bmsc_pkg::ModeW-1:0]     m_mode;
  logic                           m_asleep;
  logic                           m_last;
  logic [bmsc_pkg::DebounceW-1:0] m_stable;
  logic                           m_down;
  logic                           m_prev_down;
  logic                           m_pending;
  logic [bmsc_pkg::HoldW-1:0]     m_hold;
  logic [bmsc_pkg::SessionW-1:0]  m_session;

  logic   sample_q[$];
  drive_t drive_q[$];
  bit     in_taken;
  bit     out_taken;
  int     gap_max = 8;
  int     gap_left;
  int     stall_left;
  int     hold_left;
  bit     hold_req;
  int     mismatch_count;

  function automatic drive_t tick_drives(input logic level);
    logic   press;
    logic   released;
    logic   held_long;
    logic   expired;
    drive_t r;
    if (level != m_last) begin
      m_last = level;
      m_stable = '0;
    end else if (m_stable != bmsc_pkg::StableMax) begin
      m_stable++;
    end
    if (m_stable >= lim_debounce) m_down = !m_last;
    press = m_down && !m_prev_down;
    m_prev_down = m_down;
    if (m_asleep) begin
      if (press) begin
        m_asleep = 1'b0;
        m_session = '0;
      end
    end else begin
      if (m_session != bmsc_pkg::SessionMax) m_session++;
      if (press) begin
        m_pending = 1'b1;
        m_hold = '0;
      end else if (m_pending && m_down && m_hold != bmsc_pkg::HoldMax) begin
        m_hold++;
      end
      released = m_pending && !m_down;
      held_long = m_pending && m_down && (m_hold >= lim_long);
      expired = m_session >= lim_session;
      if (held_long || expired) begin
        m_asleep = 1'b1;
        m_pending = 1'b0;
        m_hold = '0;
        m_session = '0;
      end else if (released) begin
        m_pending = 1'b0;
        m_mode++;
        m_session = '0;
      end
    end
    r.heater = !m_asleep && m_mode[1];
    r.left = !m_asleep && !m_mode[0];
    r.right = !m_asleep && m_mode[0];
    r.sleeping = m_asleep;
    r.mode = m_mode;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // monitor: register writes, accepted samples and result beats
  always @(posedge clk) begin
    drive_t want;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          bmsc_pkg::CFG_DEBOUNCE:   lim_debounce = cfg_data[bmsc_pkg::DebounceW-1:0];
          bmsc_pkg::CFG_LONG_PRESS: lim_long = cfg_data[bmsc_pkg::HoldW-1:0];
          bmsc_pkg::CFG_SESSION:    lim_session = cfg_data[bmsc_pkg::SessionW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        drive_q.push_back(tick_drives(in_button_level));
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        if (drive_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = drive_q.pop_front();
          if (out_heater_on !== want.heater)
            report_mismatch($sformatf("heater_on %b, expected %b", out_heater_on, want.heater));
          if (out_drive_left !== want.left)
            report_mismatch($sformatf("drive_left %b, expected %b", out_drive_left, want.left));
          if (out_drive_right !== want.right)
            report_mismatch($sformatf("drive_right %b, expected %b", out_drive_right,
                                      want.right));
          if (out_sleeping !== want.sleeping)
            report_mismatch($sformatf("sleeping %b, expected %b", out_sleeping, want.sleeping));
          if (out_current_mode !== want.mode)
            report_mismatch($sformatf("current_mode %0d, expected %0d", out_current_mode,
                                      want.mode));
        end
      end
    end
  end

  // driver: one sample beat per queued sample, random gap after each
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_valid <= 1'b1;
        in_button_level <= sample_q.pop_front();
        gap_left = $urandom_range(0, gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall per result beat, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 60;
    end
    if (out_taken) stall_left = $urandom_range(0, gap_max);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // check just after the falling edge so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk);
    #1;
    while (sample_q.size() != 0 || in_valid || out_valid || drive_q.size() != 0) begin
      @(negedge clk);
      #1;
    end
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bmsc_pkg::CfgIdxW-1:0] idx,
                           input logic [bmsc_pkg::CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(input int deb, input int lp, input int sess);
    wait_drained();
    write_reg(bmsc_pkg::CFG_DEBOUNCE, {16'($urandom), 8'(deb)});
    write_reg(bmsc_pkg::CFG_LONG_PRESS, {8'($urandom), 16'(lp)});
    write_reg(bmsc_pkg::CFG_SESSION, 24'(sess));
  endtask

  task automatic push_run(input logic level, input int len);
    repeat (len) sample_q.push_back(level);
  endtask

  task automatic push_levels(input logic levels[]);
    foreach (levels[i]) sample_q.push_back(levels[i]);
  endtask

  // mostly debounced presses of random length, with idle runs, glitches and noise
  task automatic random_presses(input int deb, input int lp, input int sess, input int n);
    int made;
    int hold_len;
    int rel_len;
    int kind;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      hold_len = 0;
      rel_len = 0;
      if (kind <= 4) begin
        hold_len = $urandom_range(deb + 1, deb + lp + 3);
        rel_len = $urandom_range(deb + 1, deb + 6);
      end else if (kind <= 6) begin
        rel_len = $urandom_range(1, sess + deb + 4);
      end else if (kind == 7) begin
        hold_len = $urandom_range(1, deb + 1);
        rel_len = $urandom_range(1, deb + 1);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 6)) begin
          sample_q.push_back(1'($urandom));
          made++;
        end
      end else begin
        hold_len = deb + lp + $urandom_range(1, 4);
        rel_len = $urandom_range(deb + 1, deb + 6);
      end
      if (hold_len > 300) hold_len = 300;
      if (rel_len > 300) rel_len = 300;
      push_run(1'b0, hold_len);
      push_run(1'b1, rel_len);
      made += hold_len + rel_len;
    end
  endtask

  initial begin
    lim_debounce = bmsc_pkg::DebounceReset;
    lim_long = bmsc_pkg::LongPressReset;
    lim_session = bmsc_pkg::SessionReset;
    m_mode = '0;
    m_asleep = 1'b1;
    m_last = 1'b1;
    m_stable = '0;
    m_down = 1'b0;
    m_prev_down = 1'b0;
    m_pending = 1'b0;
    m_hold = '0;
    m_session = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: nothing gets past the debounce
    push_levels('{1'b0, 1'b0, 1'b1});

    // immediate debounce: wake, consumed release, short press, long press, timeout
    set_limits(0, 3, 6);
    write_reg(CfgSpare, '1);
    push_levels('{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0});
    push_run(1'b1, 7);

    // zero limits: sleep on first awake tick, then on the press tick
    set_limits(0, 0, 0);
    push_levels('{1'b0, 1'b1});
    wait_drained();
    write_reg(bmsc_pkg::CFG_SESSION, 24'd50);
    push_levels('{1'b0, 1'b1, 1'b0, 1'b1});

    // widest limits, debounce counter saturates
    set_limits(255, 65535, 16777215);
    gap_max = 0;
    push_run(1'b0, 270);
    push_run(1'b1, 270);

    for (int p = 0; p < 9; p++) begin
      int deb;
      int lp;
      int sess;
      deb = $urandom_range(0, 5);
      lp = $urandom_range(0, 30);
      sess = $urandom_range(0, 120);
      if (p == 5) begin
        deb = 1;
        lp = 1;
        sess = 1;
      end
      set_limits(deb, lp, sess);
      gap_max = (p % 3 == 1) ? 0 : 8;
      if (p == 2) hold_req = 1'b1;
      random_presses(deb, lp, sess, 80);
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** button_mode_session_controller: PASSED **");
    end else begin
      $display("** button_mode_session_controller: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** button_mode_session_controller: FAILED **");
    $finish;
  end

endmodule
